>>> rtl/gaussian_box_muller_3d_core_defines.svh
// Assertion macros shared by the core. The clock is clk and the reset is arst_n.
`ifndef GAUSSIAN_BOX_MULLER_3D_CORE_DEFINES_SVH
`define GAUSSIAN_BOX_MULLER_3D_CORE_DEFINES_SVH

`define GBM3_ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: property failed");

`define GBM3_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: property failed");

`endif

>>> rtl/gbm3_pkg.sv
package gbm3_pkg;

	localparam int RAD_SQ_STEPS = 30;
	localparam int SQRT_STEPS = 32;
	localparam int RAD_LAT = 2 + RAD_SQ_STEPS + 2 + SQRT_STEPS;
	localparam int HORNER_STEPS = 6;
	localparam int ANG_LAT = 3 + 3 * HORNER_STEPS + 1;
	localparam int OUT_LAT = RAD_LAT + 3;

	localparam logic [27:0] LN2_Q28 = 28'd186065279;
	localparam logic [31:0] PI_Q30 = 32'd3373259426;
	localparam logic [30:0] Q30_ONE = 31'h4000_0000;

	typedef logic [7:0] div_t;
	typedef logic [31:0] recip_t;

	localparam div_t COS_DIV [HORNER_STEPS] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
	localparam div_t SIN_DIV [HORNER_STEPS] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};

	// Reciprocals are floor(2^32 / divisor).
	localparam recip_t COS_RECIP [HORNER_STEPS] = '{
		32'd32537631, 32'd47721858, 32'd76695844,
		32'd143165576, 32'd357913941, 32'd2147483648
	};
	localparam recip_t SIN_RECIP [HORNER_STEPS] = '{
		32'd27531841, 32'd39045157, 32'd59652323,
		32'd102261126, 32'd214748364, 32'd715827882
	};

	typedef enum logic [2:0] {
		REG_MEAN_X  = 3'd0,
		REG_MEAN_Y  = 3'd1,
		REG_MEAN_Z  = 3'd2,
		REG_SIGMA_X = 3'd3,
		REG_SIGMA_Y = 3'd4,
		REG_SIGMA_Z = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [30:0] mag;
		logic        neg;
	} ang_res_t;

endpackage

>>> rtl/gbm3_radius.sv
module gbm3_radius #(
	parameter int UNIFORM_BITS = 24
) (
	input  logic                    clk,
	input  logic [UNIFORM_BITS-1:0] u,
	output logic [31:0]             rad
);

	localparam int SH = 32 - UNIFORM_BITS;
	localparam int NSQ = gbm3_pkg::RAD_SQ_STEPS;
	localparam int NRT = gbm3_pkg::SQRT_STEPS;

	logic [UNIFORM_BITS-1:0] neg_u;
	logic [31:0]             w_s1;
	logic                    zero_s1;
	logic [4:0]              lz;

	logic [31:0] sq_m [NSQ+1];
	logic [29:0] sq_f [NSQ+1];
	logic [5:0]  sq_k [NSQ+1];
	logic        sq_z [NSQ+1];
	logic [63:0] sq_p [NSQ+1];

	logic [35:0] ell;
	logic [45:0] plo_s33;
	logic [45:0] phi_s33;
	logic [63:0] tsum;

	logic [63:0] rt_n [NRT+1];
	logic [63:0] rt_r [NRT+1];
	logic [63:0] rt_sum [NRT+1];
	logic [63:0] rt_bit [NRT+1];

	assign neg_u = '0 - u;

	always_ff @(posedge clk) begin
		w_s1 <= 32'(neg_u) << SH;
		zero_s1 <= (u == '0);
	end

	always_comb begin
		lz = '0;
		for (int i = 0; i < 32; i++) begin
			if (w_s1[i]) begin
				lz = 5'(31 - i);
			end
		end
	end

	always_comb begin
		sq_p[0] = '0;
		for (int i = 1; i <= NSQ; i++) begin
			sq_p[i] = 64'(sq_m[i-1]) * 64'(sq_m[i-1]);
		end
	end

	// Each squaring of the mantissa yields one fraction bit of log2.
	always_ff @(posedge clk) begin
		sq_m[0] <= w_s1 << lz;
		sq_f[0] <= '0;
		sq_k[0] <= 6'(lz) + 6'd1;
		sq_z[0] <= zero_s1;
		for (int i = 1; i <= NSQ; i++) begin
			if (sq_p[i][63]) begin
				sq_m[i] <= sq_p[i][63:32];
				sq_f[i] <= sq_f[i-1] | (30'd1 << (30 - i));
			end else begin
				sq_m[i] <= sq_p[i][62:31];
				sq_f[i] <= sq_f[i-1];
			end
			sq_k[i] <= sq_k[i-1];
			sq_z[i] <= sq_z[i-1];
		end
	end

	assign ell = sq_z[NSQ] ? 36'd0 : ({sq_k[NSQ], 30'd0} - 36'(sq_f[NSQ]));

	always_ff @(posedge clk) begin
		plo_s33 <= 46'(ell[17:0]) * 46'(gbm3_pkg::LN2_Q28);
		phi_s33 <= 46'(ell[35:18]) * 46'(gbm3_pkg::LN2_Q28);
	end

	assign tsum = (64'(phi_s33) << 18) + 64'(plo_s33);

	always_comb begin
		rt_sum[0] = '0;
		rt_bit[0] = '0;
		for (int j = 1; j <= NRT; j++) begin
			rt_bit[j] = 64'd1 << (2 * (NRT - j));
			rt_sum[j] = rt_r[j-1] + rt_bit[j];
		end
	end

	always_ff @(posedge clk) begin
		rt_n[0] <= 64'(tsum[63:29]) << 28;
		rt_r[0] <= '0;
		for (int j = 1; j <= NRT; j++) begin
			if (rt_n[j-1] >= rt_sum[j]) begin
				rt_n[j] <= rt_n[j-1] - rt_sum[j];
				rt_r[j] <= (rt_r[j-1] >> 1) + rt_bit[j];
			end else begin
				rt_n[j] <= rt_n[j-1];
				rt_r[j] <= rt_r[j-1] >> 1;
			end
		end
	end

	assign rad = rt_r[NRT][31:0];

endmodule

>>> rtl/gbm3_angle.sv
module gbm3_angle #(
	parameter int UNIFORM_BITS = 24
) (
	input  logic                     clk,
	input  logic [UNIFORM_BITS-1:0]  a,
	output gbm3_pkg::ang_res_t       res
);

	localparam int SH = 32 - UNIFORM_BITS;
	localparam int NH = gbm3_pkg::HORNER_STEPS;
	localparam int NE = 3 * NH;

	logic [31:0] p;
	logic [29:0] g_s1;
	logic [2:0]  oct_s1;
	logic [29:0] x_s2;
	logic [2:0]  oct_s2;

	logic [29:0] hs_x   [NE+1];
	logic [29:0] hs_x2  [NE+1];
	logic [2:0]  hs_oct [NE+1];
	logic [30:0] hs_acc [NE+1];
	logic [29:0] hs_q   [NE+1];
	logic [29:0] hs_qe  [NE+1];

	logic [60:0] pq   [NH];
	logic [61:0] pr   [NH];
	logic [37:0] rem  [NH];
	logic [29:0] qf   [NH];
	logic [7:0]  dsel [NH];
	logic [60:0] psin;

	assign p = 32'(a) << SH;

	always_ff @(posedge clk) begin
		oct_s1 <= p[31:29];
		g_s1 <= p[29] ? (30'h2000_0000 - 30'(p[28:0])) : 30'(p[28:0]);
		x_s2 <= 30'((62'(g_s1) * 62'(gbm3_pkg::PI_Q30)) >> 31);
		oct_s2 <= oct_s1;
	end

	// Horner steps take three stages: product, reciprocal estimate, correction.
	always_comb begin
		for (int j = 0; j < NH; j++) begin
			pq[j] = 61'(hs_x2[3*j]) * 61'(hs_acc[3*j]);
			pr[j] = 62'(hs_q[3*j+1]) * 62'((hs_oct[3*j+1][0] ^ hs_oct[3*j+1][1])
				? gbm3_pkg::SIN_RECIP[j] : gbm3_pkg::COS_RECIP[j]);
			dsel[j] = (hs_oct[3*j+2][0] ^ hs_oct[3*j+2][1])
				? gbm3_pkg::SIN_DIV[j] : gbm3_pkg::COS_DIV[j];
			rem[j] = 38'(hs_q[3*j+2]) - 38'(hs_qe[3*j+2]) * 38'(dsel[j]);
			qf[j] = (rem[j] >= 38'(dsel[j])) ? (hs_qe[3*j+2] + 30'd1) : hs_qe[3*j+2];
		end
	end

	always_ff @(posedge clk) begin
		hs_x[0] <= x_s2;
		hs_x2[0] <= 30'((60'(x_s2) * 60'(x_s2)) >> 30);
		hs_oct[0] <= oct_s2;
		hs_acc[0] <= gbm3_pkg::Q30_ONE;
		hs_q[0] <= '0;
		hs_qe[0] <= '0;
		for (int e = 1; e <= NE; e++) begin
			hs_x[e] <= hs_x[e-1];
			hs_x2[e] <= hs_x2[e-1];
			hs_oct[e] <= hs_oct[e-1];
			if (e % 3 == 1) begin
				hs_q[e] <= 30'(pq[(e-1)/3] >> 30);
			end else begin
				hs_q[e] <= hs_q[e-1];
			end
			if (e % 3 == 2) begin
				hs_qe[e] <= 30'(pr[(e-2)/3] >> 32);
			end else begin
				hs_qe[e] <= hs_qe[e-1];
			end
			if (e % 3 == 0) begin
				hs_acc[e] <= gbm3_pkg::Q30_ONE - 31'(qf[e/3-1]);
			end else begin
				hs_acc[e] <= hs_acc[e-1];
			end
		end
	end

	assign psin = 61'(hs_x[NE]) * 61'(hs_acc[NE]);

	always_ff @(posedge clk) begin
		res.mag <= (hs_oct[NE][0] ^ hs_oct[NE][1]) ? 31'(psin >> 30) : hs_acc[NE];
		res.neg <= hs_oct[NE][2] ^ hs_oct[NE][1];
	end

endmodule

>>> rtl/gaussian_box_muller_3d_core.sv
// Three-axis Gaussian sample generator. A transaction is taken at every clock edge at
// which start is high; busy is always low, so one item may follow another on every
// cycle. Each result appears on the sample ports 69 cycles after its start, marked by
// a one-cycle done strobe, and must be captured then. The latency is set by the
// 30-stage squaring chain of the logarithm and the 32-stage square root in each
// radius pipeline. Configuration writes take effect at once and are to be made only
// while no transaction is in flight.
`include "gaussian_box_muller_3d_core_defines.svh"

module gaussian_box_muller_3d_core #(
	parameter int UNIFORM_BITS = 24
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [UNIFORM_BITS-1:0]  radius_u_x,
	input  logic [UNIFORM_BITS-1:0]  angle_u_x,
	input  logic [UNIFORM_BITS-1:0]  radius_u_y,
	input  logic [UNIFORM_BITS-1:0]  angle_u_y,
	input  logic [UNIFORM_BITS-1:0]  radius_u_z,
	input  logic [UNIFORM_BITS-1:0]  angle_u_z,
	input  logic                     cfg_we,
	input  logic [2:0]               cfg_index,
	input  logic [31:0]              cfg_wdata,
	output logic                     done,
	output logic signed [31:0]       sample_x,
	output logic signed [31:0]       sample_y,
	output logic signed [31:0]       sample_z,
	output logic                     clipped
);

	localparam int DLY = gbm3_pkg::RAD_LAT - gbm3_pkg::ANG_LAT;
	localparam int LAT = gbm3_pkg::OUT_LAT;
	localparam logic signed [33:0] SAT_MAX = 34'sd2147483647;
	localparam logic signed [33:0] SAT_MIN = -34'sd2147483648;

	logic [UNIFORM_BITS-1:0] ur [3];
	logic [UNIFORM_BITS-1:0] ua [3];
	logic [31:0]             rad [3];
	gbm3_pkg::ang_res_t      ang [3];
	gbm3_pkg::ang_res_t      dl_s [3][DLY];

	logic signed [31:0] mean_q [3];
	logic [23:0]        sigma_q [3];
	logic [LAT-1:0]     vld_q;

	logic [31:0]        mag_s1 [3];
	logic               neg_s1 [3];
	logic [55:0]        prd_s2 [3];
	logic               neg_s2 [3];
	logic [28:0]        dev [3];
	logic signed [33:0] sum [3];
	logic signed [31:0] smp_q [3];
	logic [2:0]         clip_q;

	assign busy = 1'b0;

	assign ur[0] = radius_u_x;
	assign ua[0] = angle_u_x;
	assign ur[1] = radius_u_y;
	assign ua[1] = angle_u_y;
	assign ur[2] = radius_u_z;
	assign ua[2] = angle_u_z;

	for (genvar ax = 0; ax < 3; ax++) begin : g_axis
		gbm3_radius #(
			.UNIFORM_BITS(UNIFORM_BITS)
		) u_radius (
			.clk(clk),
			.u(ur[ax]),
			.rad(rad[ax])
		);

		gbm3_angle #(
			.UNIFORM_BITS(UNIFORM_BITS)
		) u_angle (
			.clk(clk),
			.a(ua[ax]),
			.res(ang[ax])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				mean_q[i] <= '0;
				sigma_q[i] <= 24'h01_0000;
			end
		end else if (cfg_we) begin
			unique case (gbm3_pkg::reg_idx_t'(cfg_index))
				gbm3_pkg::REG_MEAN_X: mean_q[0] <= cfg_wdata;
				gbm3_pkg::REG_MEAN_Y: mean_q[1] <= cfg_wdata;
				gbm3_pkg::REG_MEAN_Z: mean_q[2] <= cfg_wdata;
				gbm3_pkg::REG_SIGMA_X: sigma_q[0] <= cfg_wdata[23:0];
				gbm3_pkg::REG_SIGMA_Y: sigma_q[1] <= cfg_wdata[23:0];
				gbm3_pkg::REG_SIGMA_Z: sigma_q[2] <= cfg_wdata[23:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start & ~busy};
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dev[i] = 29'((57'(prd_s2[i]) + (57'd1 << 27)) >> 28);
			sum[i] = neg_s2[i] ? (34'(mean_q[i]) - signed'(34'(dev[i])))
				: (34'(mean_q[i]) + signed'(34'(dev[i])));
		end
	end

	// The angle result waits for the longer radius pipeline before the two meet.
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			dl_s[i][0] <= ang[i];
			for (int d = 1; d < DLY; d++) begin
				dl_s[i][d] <= dl_s[i][d-1];
			end
			mag_s1[i] <= 32'((63'(rad[i]) * 63'(dl_s[i][DLY-1].mag)) >> 30);
			neg_s1[i] <= dl_s[i][DLY-1].neg;
			prd_s2[i] <= 56'(mag_s1[i]) * 56'(sigma_q[i]);
			neg_s2[i] <= neg_s1[i];
			if (sum[i] > SAT_MAX) begin
				smp_q[i] <= 32'(SAT_MAX);
				clip_q[i] <= 1'b1;
			end else if (sum[i] < SAT_MIN) begin
				smp_q[i] <= 32'(SAT_MIN);
				clip_q[i] <= 1'b1;
			end else begin
				smp_q[i] <= 32'(sum[i]);
				clip_q[i] <= 1'b0;
			end
		end
	end

	assign done = vld_q[LAT-1];
	assign sample_x = smp_q[0];
	assign sample_y = smp_q[1];
	assign sample_z = smp_q[2];
	assign clipped = |clip_q;

	`GBM3_ASSERT_NEXT(a_first_stage_valid, start && !busy, vld_q[0])
	`GBM3_ASSERT_IMPLIES(a_done_after_start, done, $past(start, gbm3_pkg::OUT_LAT))
	`GBM3_ASSERT_IMPLIES(a_clip_at_limit, done && clipped, (sample_x == 32'sh7fff_ffff || sample_x == 32'sh8000_0000 || sample_y == 32'sh7fff_ffff || sample_y == 32'sh8000_0000 || sample_z == 32'sh7fff_ffff || sample_z == 32'sh8000_0000))

endmodule
